### rtl/sfe_pkg.sv
// shared types, constants and crc helper for the stuffed frame encoder
// no dependencies
`timescale 1ns / 1ps

package sfe_pkg;

  localparam logic [7:0] FrmStart = 8'hAA;
  localparam logic [7:0] FrmEnd = 8'hCC;
  localparam logic [7:0] FrmEsc = 8'hEE;
  localparam logic [7:0] FrmEscStart = 8'h0A;
  localparam logic [7:0] FrmEscEnd = 8'h0C;
  localparam logic [7:0] FrmEscEsc = 8'h0E;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h8408;

  // one classified request handed from front to back
  typedef struct packed {
    logic       has_start;
    logic       is_esc;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       last;
  } desc_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/sfe_front.sv
// front end: accepts payload bytes, tracks frame open state, classifies escapes
// depends on sfe_pkg
`timescale 1ns / 1ps

module sfe_front import sfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] payload_byte_i,
  input  logic       frame_last_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output desc_t      q_desc_o
);

  logic open_q, open_d;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_desc_o.has_start = !open_q;
    q_desc_o.last      = frame_last_i;
    q_desc_o.is_esc    = 1'b1;
    q_desc_o.byte0     = FrmEsc;
    unique case (payload_byte_i)
      FrmStart: q_desc_o.byte1 = FrmEscStart;
      FrmEnd:   q_desc_o.byte1 = FrmEscEnd;
      FrmEsc:   q_desc_o.byte1 = FrmEscEsc;
      default: begin
        q_desc_o.is_esc = 1'b0;
        q_desc_o.byte0  = payload_byte_i;
        q_desc_o.byte1  = payload_byte_i;
      end
    endcase
  end

  always_comb begin
    open_d = open_q;
    if (q_push_o) begin
      open_d = !frame_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else begin
      open_q <= open_d;
    end
  end

endmodule

### rtl/sfe_fifo.sv
// two-entry request queue between front and back
// depends on sfe_pkg
`timescale 1ns / 1ps

module sfe_fifo import sfe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  head_valid_o,
  output desc_t head_desc_o
);

  desc_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_desc_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/sfe_back.sv
// back end: walks each request byte by byte, keeps the running crc, drives output register
// depends on sfe_pkg
`timescale 1ns / 1ps

module sfe_back import sfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  desc_t      head_desc_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] line_byte_o,
  output logic       run_last_o,
  output logic       frame_done_o
);

  typedef enum logic [2:0] {
    S_BEGIN,
    S_C0,
    S_C1,
    S_END,
    S_LO,
    S_HI
  } step_e;

  step_e       step_q, step_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        run_last_q, run_last_d;
  logic        done_q, done_d;

  logic        advance;
  logic        hashed;
  logic        item_done;
  logic        is_first;
  logic [7:0]  emit_byte;
  logic [15:0] crc_base;

  assign advance = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && item_done;

  always_comb begin
    emit_byte = head_desc_i.byte0;
    hashed    = 1'b1;
    item_done = 1'b0;
    is_first  = 1'b0;
    step_d    = step_q;
    done_d    = 1'b0;
    unique case (step_q)
      S_BEGIN, S_C0: begin
        if (step_q == S_BEGIN && head_desc_i.has_start) begin
          emit_byte = FrmStart;
          is_first  = 1'b1;
          step_d    = S_C0;
        end else if (head_desc_i.is_esc) begin
          step_d = S_C1;
        end else if (head_desc_i.last) begin
          step_d = S_END;
        end else begin
          item_done = 1'b1;
          step_d    = S_BEGIN;
        end
      end
      S_C1: begin
        emit_byte = head_desc_i.byte1;
        if (head_desc_i.last) begin
          step_d = S_END;
        end else begin
          item_done = 1'b1;
          step_d    = S_BEGIN;
        end
      end
      S_END: begin
        emit_byte = FrmEnd;
        step_d    = S_LO;
      end
      S_LO: begin
        emit_byte = crc_q[7:0];
        hashed    = 1'b0;
        step_d    = S_HI;
      end
      S_HI: begin
        emit_byte = crc_q[15:8];
        hashed    = 1'b0;
        item_done = 1'b1;
        done_d    = 1'b1;
        step_d    = S_BEGIN;
      end
      default: begin
        step_d = S_BEGIN;
      end
    endcase
  end

  // a new frame restarts the crc at the start byte
  assign crc_base = is_first ? CrcInit : crc_q;

  always_comb begin
    crc_d       = crc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    run_last_d  = run_last_q;
    if (advance) begin
      out_valid_d = 1'b1;
      byte_d      = emit_byte;
      run_last_d  = item_done;
      if (hashed) begin
        crc_d = crc_feed(crc_base, emit_byte);
      end else if (done_d) begin
        crc_d = CrcInit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_BEGIN;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
      byte_q      <= 8'h00;
      run_last_q  <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        step_q     <= step_d;
        byte_q     <= byte_d;
        run_last_q <= run_last_d;
        done_q     <= done_d;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_byte_o  = byte_q;
  assign run_last_o   = run_last_q;
  assign frame_done_o = done_q;

endmodule

### rtl/stuffed_frame_encoder_crc16_top.sv
// byte stuffing framer with crc-16, low crc byte first after the end byte
// an accepted request is written into the queue, then its first line byte into the output register
// throughput: one line byte per cycle while the output is ready, set by the back end
// sequencer; a request makes one to six line bytes, so plain mid-frame bytes flow at one per cycle
// reset: asynchronous active low, clears frame state, queue and output register
// depends on sfe_pkg, sfe_front, sfe_fifo, sfe_back
`timescale 1ns / 1ps

module stuffed_frame_encoder_crc16_top import sfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] payload_byte_i,
  input  logic       frame_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] line_byte_o,
  output logic       run_last_o,
  output logic       frame_done_o
);

  logic  q_full;
  logic  q_push;
  desc_t q_desc;
  logic  q_pop;
  logic  head_valid;
  desc_t head_desc;

  sfe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .payload_byte_i (payload_byte_i),
    .frame_last_i   (frame_last_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_desc_o       (q_desc)
  );

  sfe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_desc_i  (q_desc),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (head_valid),
    .head_desc_o  (head_desc)
  );

  sfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_desc_i  (head_desc),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_byte_o  (line_byte_o),
    .run_last_o   (run_last_o),
    .frame_done_o (frame_done_o)
  );

endmodule

### dv/tb_stuffed_frame_encoder_crc16_top.sv
// self-checking testbench for stuffed_frame_encoder_crc16_top: framing, escapes and crc-16
// depends on sfe_pkg for the frame constants and on the rtl top level
`timescale 1ns / 1ps

module tb_stuffed_frame_encoder_crc16_top;
  import sfe_pkg::*;

  localparam int unsigned ClkHalf = 6;
  localparam int unsigned RunLimit = 400000;
  localparam int unsigned IdlePct = 32;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_done;
  } line_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] payload_byte_i = 8'h00;
  logic       frame_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] line_byte_o;
  logic       run_last_o;
  logic       frame_done_o;

  // predictor state
  logic        frame_open = 1'b0;
  logic [15:0] crc_acc = CrcInit;
  line_beat_t  pending_line_q[$];

  logic        no_idle = 1'b0;
  int unsigned err_cnt = 0;
  int unsigned requests_sent = 0;
  int unsigned frames_closed = 0;
  int unsigned escapes_sent = 0;
  int unsigned line_bytes_checked = 0;

  stuffed_frame_encoder_crc16_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .payload_byte_i(payload_byte_i),
    .frame_last_i  (frame_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .line_byte_o   (line_byte_o),
    .run_last_o    (run_last_o),
    .frame_done_o  (frame_done_o)
  );

  initial begin
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  initial begin
    repeat (RunLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d line bytes still pending", RunLimit,
             pending_line_q.size());
    $display("FAIL stuffed_frame_encoder_crc16_top");
    $finish;
  end

  // reflected crc-16, poly 0x8408, one byte lsb first
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    r = acc ^ {8'h00, data};
    repeat (8) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  task automatic predict_line_bytes(input logic [7:0] b, input logic last);
    logic [7:0] body[$];
    line_beat_t beats[$];
    line_beat_t tail;
    if (!frame_open) begin
      crc_acc = CrcInit;
      body.push_back(FrmStart);
      frame_open = 1'b1;
    end
    case (b)
      FrmStart: begin
        body.push_back(FrmEsc);
        body.push_back(FrmEscStart);
      end
      FrmEnd: begin
        body.push_back(FrmEsc);
        body.push_back(FrmEscEnd);
      end
      FrmEsc: begin
        body.push_back(FrmEsc);
        body.push_back(FrmEscEsc);
      end
      default: body.push_back(b);
    endcase
    if (b == FrmStart || b == FrmEnd || b == FrmEsc) escapes_sent++;
    if (last) body.push_back(FrmEnd);
    foreach (body[i]) begin
      crc_acc = crc16_fold(crc_acc, body[i]);
      beats.push_back('{data: body[i], run_last: 1'b0, frame_done: 1'b0});
    end
    if (last) begin
      // crc bytes go out unhashed, low byte first
      beats.push_back('{data: crc_acc[7:0], run_last: 1'b0, frame_done: 1'b0});
      beats.push_back('{data: crc_acc[15:8], run_last: 1'b0, frame_done: 1'b1});
      frame_open = 1'b0;
      crc_acc = CrcInit;
      frames_closed++;
    end
    tail = beats.pop_back();
    tail.run_last = 1'b1;
    beats.push_back(tail);
    foreach (beats[i]) pending_line_q.push_back(beats[i]);
  endtask

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // called at a rising edge; returns at the edge that accepts the request
  task automatic send_request(input logic [7:0] b, input logic last);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    payload_byte_i <= b;
    frame_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
    predict_line_bytes(b, last);
  endtask

  // receiver: check each accepted line byte, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_line_q.size() == 0) begin
        report_mismatch($sformatf("unexpected line byte %h run_last %b frame_done %b",
                                  line_byte_o, run_last_o, frame_done_o));
      end else begin
        line_beat_t exp_beat;
        exp_beat = pending_line_q.pop_front();
        line_bytes_checked++;
        if (line_byte_o !== exp_beat.data || run_last_o !== exp_beat.run_last ||
            frame_done_o !== exp_beat.frame_done) begin
          report_mismatch($sformatf("byte %0d: got %h/%b/%b, want %h/%b/%b",
                                    line_bytes_checked, line_byte_o, run_last_o,
                                    frame_done_o, exp_beat.data, exp_beat.run_last,
                                    exp_beat.frame_done));
        end
      end
    end
    out_ready_i <= no_idle || ($urandom_range(99) >= IdlePct);
  end

  function automatic logic [7:0] pick_payload();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 12) return FrmStart;
    if (sel < 20) return FrmEnd;
    if (sel < 28) return FrmEsc;
    // the escape second bytes are plain data and must pass through untouched
    if (sel < 34) return (sel[0]) ? FrmEscStart : FrmEscEsc;
    if (sel < 36) return FrmEscEnd;
    return 8'($urandom_range(255));
  endfunction

  function automatic int unsigned pick_frame_len();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(4, 1);
    if (sel < 95) return $urandom_range(12, 5);
    return $urandom_range(40, 13);
  endfunction

  task automatic send_frame(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_request(pick_payload(), (i == len - 1));
    end
  endtask

  // every special byte and a few plain ones as whole frames of one byte
  task automatic test_single_byte_frames();
    logic [7:0] lone_bytes[9];
    lone_bytes = '{8'h00, 8'hFF, FrmStart, FrmEnd, FrmEsc, FrmEscStart, FrmEscEnd,
                   FrmEscEsc, 8'h55};
    foreach (lone_bytes[i]) send_request(lone_bytes[i], 1'b1);
  endtask

  // escapes at the start, middle and close of longer frames
  task automatic test_escape_runs();
    logic [7:0] run_a[8];
    run_a = '{FrmStart, FrmEnd, FrmEsc, FrmEscEsc, FrmEscEnd, FrmEscStart, 8'h80, 8'h01};
    foreach (run_a[i]) send_request(run_a[i], (i == 7));
    send_request(FrmEsc, 1'b0);
    send_request(FrmStart, 1'b1);
    send_request(8'h7F, 1'b0);
    send_request(8'hFE, 1'b0);
    send_request(FrmEnd, 1'b1);
  endtask

  task automatic test_random_frames(input int unsigned target);
    int unsigned start_cnt;
    start_cnt = requests_sent;
    while (requests_sent - start_cnt < target) send_frame(pick_frame_len());
  endtask

  // full rate on both sides, no idle cycles at all
  task automatic test_streaming(input int unsigned target);
    no_idle = 1'b1;
    test_random_frames(target);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_byte_frames();
    test_escape_runs();
    test_random_frames(150);
    test_streaming(80);
    test_random_frames(60);
    in_valid_i <= 1'b0;

    while (pending_line_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d requests in %0d frames (%0d escaped bytes)", requests_sent,
             frames_closed, escapes_sent);
    $display("checked %0d line bytes, %0d mismatches", line_bytes_checked, err_cnt);
    if (err_cnt == 0 && pending_line_q.size() == 0) begin
      $display("PASS stuffed_frame_encoder_crc16_top");
    end else begin
      $display("FAIL stuffed_frame_encoder_crc16_top");
    end
    $finish;
  end

endmodule
